### design/sac_pkg.sv
`default_nettype none

package sac_pkg;

  typedef logic [2:0] action_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] mode_t;

  localparam mode_t MODE_OFF   = 2'd0;
  localparam mode_t MODE_HOLD  = 2'd1;
  localparam mode_t MODE_OPEN  = 2'd2;
  localparam mode_t MODE_CLOSE = 2'd3;

  localparam status_t ST_STOPPED = 3'd0;
  localparam status_t ST_MOVING  = 3'd1;
  localparam status_t ST_TOP     = 3'd2;
  localparam status_t ST_BOTTOM  = 3'd3;
  localparam status_t ST_ERROR   = 3'd4;

  localparam action_t ACT_OFF   = 3'd0;
  localparam action_t ACT_HOLD  = 3'd1;
  localparam action_t ACT_OPEN  = 3'd2;
  localparam action_t ACT_CLOSE = 3'd3;
  localparam action_t ACT_STEP  = 3'd4;
  localparam action_t ACT_POLL  = 3'd5;
  localparam action_t ACT_ZERO  = 3'd6;

  localparam logic [1:0] CFG_MSTEPS      = 2'd0;
  localparam logic [1:0] CFG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SPEED_DIV   = 2'd2;
  localparam logic [1:0] CFG_ANGLE_SCALE = 2'd3;

  localparam logic [14:0] MSTEPS_RESET      = 15'd20800;
  localparam logic [15:0] SPEED_LIMIT_RESET = 16'd1000;
  localparam logic [15:0] SPEED_DIV_RESET   = 16'd600;
  localparam logic [30:0] ANGLE_SCALE_RESET = 31'd36000;

  localparam logic [19:0] TICK_BASE    = 20'd1000000;
  localparam logic [13:0] FREQ_LOW     = 14'd16;
  localparam logic [13:0] FREQ_HIGH    = 14'd10000;
  localparam logic [15:0] PERIOD_RESET = 16'd100;
  localparam logic [15:0] PERIOD_MAX   = 16'd62500;

endpackage

`default_nettype wire

### design/sac_cmd_if.sv
`default_nettype none

interface sac_cmd_if;
  logic              valid;
  logic              ready;
  sac_pkg::action_t  action;
  logic [15:0]       speed;
  logic              limit_top;
  logic              limit_bottom;

  modport source (output valid, action, speed, limit_top, limit_bottom, input ready);
  modport sink   (input valid, action, speed, limit_top, limit_bottom, output ready);
endinterface

`default_nettype wire

### design/sac_res_if.sv
`default_nettype none

interface sac_res_if;
  logic               valid;
  logic               ready;
  sac_pkg::status_t   status;
  logic               drive_enable;
  logic               direction_close;
  logic               stepping;
  logic [15:0]        step_period;
  logic signed [31:0] position_angle;

  modport source (output valid, status, drive_enable, direction_close, stepping,
                  step_period, position_angle, input ready);
  modport sink   (input valid, status, drive_enable, direction_close, stepping,
                  step_period, position_angle, output ready);
endinterface

`default_nettype wire

### design/sac_muldiv.sv
`default_nettype none

// Computes a * b / d: shift-and-add multiply, one bit of b per cycle, then
// restoring division, one quotient bit per cycle.
module sac_muldiv #(
  parameter int unsigned WA = 20,
  parameter int unsigned WB = 15,
  parameter int unsigned WD = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WA-1:0]        a_i,
  input  wire logic [WB-1:0]        b_i,
  input  wire logic [WD-1:0]        d_i,
  output logic                      busy_o,
  output logic [WA+WB-1:0]          quot_o
);

  localparam int unsigned N  = WA + WB;
  localparam int unsigned CW = (N > 1) ? $clog2(N) : 1;

  logic          busy_q, busy_d;
  logic          phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N-1:0]  prod_q, prod_d;
  logic [WA-1:0] a_q, a_d;
  logic [WB-1:0] b_q, b_d;
  logic [WD-1:0] d_q, d_d;
  logic [WD:0]   rem_q, rem_d;
  logic [WD:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[WD-1:0], prod_q[N-1]};
  assign ge     = (rem_sh >= {1'b0, d_q});

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    a_d     = a_q;
    b_d     = b_q;
    d_d     = d_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = CW'(WB - 1);
      prod_d  = '0;
      a_d     = a_i;
      b_d     = b_i;
      d_d     = d_i;
      rem_d   = '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        prod_d = {prod_q[N-2:0], 1'b0} + (b_q[WB-1] ? {{WB{1'b0}}, a_q} : '0);
        b_d    = {b_q[WB-2:0], 1'b0};
        if (cnt_q == '0) begin
          phase_d = 1'b1;
          cnt_d   = CW'(N - 1);
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end else begin
        rem_d  = ge ? (rem_sh - {1'b0, d_q}) : rem_sh;
        prod_d = {prod_q[N-2:0], ge};
        if (cnt_q == '0) begin
          busy_d = 1'b0;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a_q    <= a_d;
    b_q    <= b_d;
    d_q    <= d_d;
    rem_q  <= rem_d;
  end

  assign busy_o = busy_q;
  assign quot_o = prod_q;

endmodule

`default_nettype wire

### design/stepper_axis_controller.sv
`default_nettype none

// Channel   Dir  Payload
// cmd       in   action, speed, limit_top, limit_bottom
// res       out  status, drive_enable, direction_close, stepping, step_period,
//                position_angle
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One request is in flight at a time. The angle unit works through 16
// multiply bits and then 47 quotient bits for every request.
// An open or close request with a new nonzero speed runs two passes of the
// speed unit in series, a frequency pass and then a period pass; with a zero
// divisor only the period pass runs.
// Reset restores the register defaults and puts the axis in off mode.
// A result waiting on res does not block the next request from being accepted.
module stepper_axis_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [30:0] cfg_data_i,
  sac_cmd_if.sink          cmd,
  sac_res_if.source        res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FRQ  = 2'd1;
  localparam logic [1:0] S_PER  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state_q, state_d;

  logic [14:0] msteps_q;
  logic [15:0] spd_lim_q;
  logic [15:0] div_q;
  logic [30:0] scale_q;

  sac_pkg::mode_t   mode_q, mode_d, mode_t0, nxt;
  logic [15:0]      pos_q, pos_d;
  logic [15:0]      prev_q, prev_d;
  logic [15:0]      period_q, period_d;
  logic             dir_q, dir_d;
  sac_pkg::status_t sts_q, sts_d;
  logic             neg_q;

  logic             accept;
  logic             do_tr;
  logic             launch_spd;
  logic [15:0]      spd_c;

  logic             su_start, su_per, su_busy;
  logic [13:0]      su_freq, freq_c;
  logic [19:0]      su_a;
  logic [14:0]      su_b;
  logic [15:0]      su_d;
  logic [34:0]      su_quot;

  logic             ang_busy;
  logic [15:0]      pos_mag;
  logic [46:0]      ang_quot;
  logic [31:0]      ang_val;

  logic             res_valid_q, res_valid_d;
  logic             res_load;
  sac_pkg::status_t res_sts_q;
  logic             res_en_q, res_dir_q, res_stp_q;
  logic [15:0]      res_per_q;
  logic [31:0]      res_ang_q;

  assign accept    = cmd.valid && cmd.ready;
  assign cmd.ready = (state_q == S_IDLE);

  always_comb begin
    mode_d     = mode_q;
    mode_t0    = mode_q;
    nxt        = mode_q;
    pos_d      = pos_q;
    prev_d     = prev_q;
    dir_d      = dir_q;
    sts_d      = sac_pkg::ST_STOPPED;
    do_tr      = 1'b0;
    launch_spd = 1'b0;
    case (cmd.action)
      sac_pkg::ACT_OFF, sac_pkg::ACT_HOLD: begin
        nxt   = cmd.action[1:0];
        do_tr = 1'b1;
      end
      sac_pkg::ACT_OPEN, sac_pkg::ACT_CLOSE: begin
        nxt   = cmd.action[1:0];
        do_tr = 1'b1;
        if (cmd.speed != prev_q) begin
          prev_d = cmd.speed;
          if (cmd.speed == '0) begin
            mode_t0 = sac_pkg::MODE_HOLD;
          end else begin
            launch_spd = 1'b1;
          end
        end
      end
      sac_pkg::ACT_STEP: begin
        if (mode_q == sac_pkg::MODE_CLOSE) begin
          pos_d = pos_q + 16'd1;
        end else if (mode_q == sac_pkg::MODE_OPEN) begin
          pos_d = pos_q - 16'd1;
        end
      end
      sac_pkg::ACT_POLL: begin
        do_tr = 1'b1;
      end
      sac_pkg::ACT_ZERO: begin
        pos_d = '0;
      end
      default: begin
        sts_d = sac_pkg::ST_ERROR;
      end
    endcase
    mode_d = mode_t0;
    if (do_tr) begin
      case (nxt)
        sac_pkg::MODE_OFF: begin
          mode_d = sac_pkg::MODE_OFF;
          sts_d  = sac_pkg::ST_STOPPED;
        end
        sac_pkg::MODE_HOLD: begin
          mode_d = sac_pkg::MODE_HOLD;
          sts_d  = sac_pkg::ST_STOPPED;
        end
        sac_pkg::MODE_OPEN: begin
          if (mode_t0 == sac_pkg::MODE_CLOSE) begin
            mode_d = sac_pkg::MODE_HOLD;
            sts_d  = sac_pkg::ST_ERROR;
          end else if (cmd.limit_top) begin
            if (mode_t0 != sac_pkg::MODE_HOLD) begin
              mode_d = sac_pkg::MODE_HOLD;
              pos_d  = '0;
            end
            sts_d = sac_pkg::ST_TOP;
          end else begin
            mode_d = sac_pkg::MODE_OPEN;
            dir_d  = 1'b0;
            sts_d  = sac_pkg::ST_MOVING;
          end
        end
        default: begin
          if (mode_t0 == sac_pkg::MODE_OPEN) begin
            mode_d = sac_pkg::MODE_HOLD;
            sts_d  = sac_pkg::ST_ERROR;
          end else if (cmd.limit_bottom) begin
            mode_d = sac_pkg::MODE_HOLD;
            sts_d  = sac_pkg::ST_BOTTOM;
          end else begin
            mode_d = sac_pkg::MODE_CLOSE;
            dir_d  = 1'b1;
            sts_d  = sac_pkg::ST_MOVING;
          end
        end
      endcase
    end
  end

  assign spd_c = (cmd.speed > spd_lim_q) ? spd_lim_q : cmd.speed;

  always_comb begin
    if (su_quot < {21'd0, sac_pkg::FREQ_LOW}) begin
      freq_c = sac_pkg::FREQ_LOW;
    end else if (su_quot > {21'd0, sac_pkg::FREQ_HIGH}) begin
      freq_c = sac_pkg::FREQ_HIGH;
    end else begin
      freq_c = su_quot[13:0];
    end
  end

  always_comb begin
    su_start = 1'b0;
    su_per   = 1'b0;
    su_freq  = sac_pkg::FREQ_HIGH;
    if (accept && launch_spd) begin
      su_start = 1'b1;
      su_per   = (div_q == '0);
    end
    if (state_q == S_FRQ && !su_busy) begin
      su_start = 1'b1;
      su_per   = 1'b1;
      su_freq  = freq_c;
    end
  end

  assign su_a = su_per ? sac_pkg::TICK_BASE : {4'd0, spd_c};
  assign su_b = su_per ? 15'd1 : msteps_q;
  assign su_d = su_per ? {2'd0, su_freq} : div_q;

  sac_muldiv #(
    .WA(20),
    .WB(15),
    .WD(16)
  ) u_speed (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(su_start),
    .a_i    (su_a),
    .b_i    (su_b),
    .d_i    (su_d),
    .busy_o (su_busy),
    .quot_o (su_quot)
  );

  assign pos_mag = pos_d[15] ? (16'd0 - pos_d) : pos_d;

  sac_muldiv #(
    .WA(31),
    .WB(16),
    .WD(15)
  ) u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .a_i    (scale_q),
    .b_i    (pos_mag),
    .d_i    (msteps_q),
    .busy_o (ang_busy),
    .quot_o (ang_quot)
  );

  always_comb begin
    if (msteps_q == '0) begin
      ang_val = '0;
    end else if (!neg_q) begin
      ang_val = (ang_quot > 47'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : ang_quot[31:0];
    end else begin
      ang_val = (ang_quot > 47'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - ang_quot[31:0]);
    end
  end

  assign res_load = (state_q == S_FIN) && !ang_busy && (!res_valid_q || res.ready);

  always_comb begin
    state_d     = state_q;
    period_d    = period_q;
    res_valid_d = res_valid_q;
    if (res.ready) begin
      res_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!launch_spd) begin
            state_d = S_FIN;
          end else if (div_q == '0) begin
            state_d = S_PER;
          end else begin
            state_d = S_FRQ;
          end
        end
      end
      S_FRQ: begin
        if (!su_busy) begin
          state_d = S_PER;
        end
      end
      S_PER: begin
        if (!su_busy) begin
          period_d = su_quot[15:0];
          state_d  = S_FIN;
        end
      end
      default: begin
        if (res_load) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      msteps_q    <= sac_pkg::MSTEPS_RESET;
      spd_lim_q   <= sac_pkg::SPEED_LIMIT_RESET;
      div_q       <= sac_pkg::SPEED_DIV_RESET;
      scale_q     <= sac_pkg::ANGLE_SCALE_RESET;
      mode_q      <= sac_pkg::MODE_OFF;
      pos_q       <= '0;
      prev_q      <= '0;
      period_q    <= sac_pkg::PERIOD_RESET;
      dir_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      period_q    <= period_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sac_pkg::CFG_MSTEPS:      msteps_q  <= cfg_data_i[14:0];
          sac_pkg::CFG_SPEED_LIMIT: spd_lim_q <= cfg_data_i[15:0];
          sac_pkg::CFG_SPEED_DIV:   div_q     <= cfg_data_i[15:0];
          default:                  scale_q   <= cfg_data_i;
        endcase
      end
      if (accept) begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        prev_q <= prev_d;
        dir_q  <= dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sts_q <= sts_d;
      neg_q <= pos_d[15];
    end
    if (res_load) begin
      res_sts_q <= sts_q;
      res_en_q  <= (mode_q != sac_pkg::MODE_OFF);
      res_dir_q <= dir_q;
      res_stp_q <= (mode_q == sac_pkg::MODE_OPEN) || (mode_q == sac_pkg::MODE_CLOSE);
      res_per_q <= period_q;
      res_ang_q <= ang_val;
    end
  end

  assign res.valid           = res_valid_q;
  assign res.status          = res_sts_q;
  assign res.drive_enable    = res_en_q;
  assign res.direction_close = res_dir_q;
  assign res.stepping        = res_stp_q;
  assign res.step_period     = res_per_q;
  assign res.position_angle  = res_ang_q;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !cmd.ready)
    else $error("request accepted while a previous one is in flight");

  a_angle_done_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(!ang_busy))
    else $error("result presented before the angle unit finished");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (period_q >= sac_pkg::PERIOD_RESET) && (period_q <= sac_pkg::PERIOD_MAX))
    else $error("step period outside its range");

  a_speed_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !su_busy)
    else $error("speed unit busy with no request in flight");

endmodule

`default_nettype wire
